FILE: rtl/hufd_pkg.sv
`timescale 1ns / 1ps

package hufd_pkg;

   // tree geometry
   localparam int TREE_ENTRIES = 512;
   localparam int ADDR_W       = $clog2(TREE_ENTRIES);
   localparam int NODE_W       = ADDR_W - 1;
   localparam int ENTRY_W      = ADDR_W;
   localparam int MAX_NODE     = TREE_ENTRIES / 2 - 1;

   // field widths
   localparam int SYM_W     = 8;
   localparam int CODE_W    = 16;
   localparam int CODE_IX_W = $clog2(CODE_W);
   localparam int LEN_W     = 5;
   localparam int BYTE_W    = 8;
   localparam int BPOS_W    = $clog2(BYTE_W);
   localparam int COUNT_W   = 24;

   // command codes
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_START  = 2'd2,
      CMD_DECODE = 2'd3
   } cmd_type;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_LEAF,
      ST_DEC,
      ST_FLUSH
   } state_type;

endpackage

FILE: rtl/hufd_if.sv
`timescale 1ns / 1ps

// request channel
interface hufd_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     cmd;
   logic [hufd_pkg::SYM_W-1:0]     symbol;
   logic [hufd_pkg::CODE_W-1:0]    code_bits;
   logic [hufd_pkg::LEN_W-1:0]     code_len;
   logic [hufd_pkg::BYTE_W-1:0]    data_byte;

   modport source (output valid, cmd, symbol, code_bits, code_len, data_byte, input ready);
   modport sink (input valid, cmd, symbol, code_bits, code_len, data_byte, output ready);
endinterface

// response channel
interface hufd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [hufd_pkg::SYM_W-1:0] out_symbol;
   logic                       last_of_byte;
   logic                       stream_done;

   modport source (output valid, out_symbol, last_of_byte, stream_done, input ready);
   modport sink (input valid, out_symbol, last_of_byte, stream_done, output ready);
endinterface

// register write channel
interface hufd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [hufd_pkg::COUNT_W-1:0] symbols_total;

   modport source (output valid, symbols_total, input ready);
   modport sink (input valid, symbols_total, output ready);
endinterface

FILE: rtl/hufd_ram.sv
`timescale 1ns / 1ps

module hufd_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port (old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/huffman_tree_decoder_top.sv
`timescale 1ns / 1ps
// decode byte: accept, one data bit per cycle while no output stall holds it, then flush
// the bit rate is set by the dependent tree memory read per code bit
// add code: one read-modify-write of the tree memory per code bit, then the leaf write
// clear command and reset: sweep over all 512 tree memory entries, no request taken meanwhile
// reset is synchronous: stream state, node counter and register go to their initial values
module huffman_tree_decoder_top (
   input  logic       clock,
   input  logic       reset,
   hufd_req_if.sink   req_if,
   hufd_rsp_if.source rsp_if,
   hufd_csr_if.sink   csr_if
);

   localparam int AW = hufd_pkg::ADDR_W;
   localparam int NW = hufd_pkg::NODE_W;
   localparam int EW = hufd_pkg::ENTRY_W;
   localparam int SW = hufd_pkg::SYM_W;
   localparam int CW = hufd_pkg::COUNT_W;

   hufd_pkg::state_type state_ff, state_in;
   hufd_pkg::cmd_type   req_cmd;

   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NW-1:0] next_node_ff, next_node_in;
   logic [NW-1:0] walk_ff, walk_in;
   logic [CW-1:0] done_ff, done_in;
   logic          finished_ff, finished_in;
   logic [CW-1:0] total_ff, total_in;
   logic [AW-1:0] addr_ff, addr_in;

   logic [SW-1:0]                    sym_ff, sym_in;
   logic [hufd_pkg::CODE_W-1:0]      bits_ff, bits_in;
   logic [hufd_pkg::LEN_W-1:0]       cnt_ff, cnt_in;
   logic                             first_ff, first_in;
   logic [hufd_pkg::BYTE_W-1:0]      byte_ff, byte_in;
   logic [hufd_pkg::BPOS_W-1:0]      bpos_ff, bpos_in;

   logic          pend_valid_ff, pend_valid_in;
   logic [SW-1:0] pend_sym_ff, pend_sym_in;
   logic          pend_done_ff, pend_done_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_sym_ff, rsp_sym_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_done_ff, rsp_done_in;

   logic          fwd_hit_ff, fwd_hit_in;
   logic [EW-1:0] fwd_data_ff, fwd_data_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   logic [EW-1:0] ram_rdata;

   logic          req_take;
   logic          slot_free;
   logic [EW-1:0] rd_eff;
   logic          is_leaf;
   logic [SW-1:0] leaf_sym;
   logic          dec_stop;
   logic          dec_stall;
   logic [CW-1:0] done_inc;
   logic          done_reach;
   logic          alloc;
   logic [NW-1:0] node_inc;
   logic [EW-1:0] add_val;
   logic          add_bit;

   // tree memory
   hufd_ram #(
      .WIDTH (EW),
      .DEPTH (hufd_pkg::TREE_ENTRIES)
   ) u_tree (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_in),
      .rd_data (ram_rdata)
   );

   // handshakes
   assign req_if.ready = (state_ff == hufd_pkg::ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign req_cmd      = hufd_pkg::cmd_type'(req_if.cmd);
   assign csr_if.ready = 1'b1;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_symbol   = rsp_sym_ff;
   assign rsp_if.last_of_byte = rsp_last_ff;
   assign rsp_if.stream_done  = rsp_done_ff;

   // read data with forwarding of a same-cycle write
   assign rd_eff   = fwd_hit_ff ? fwd_data_ff : ram_rdata;
   assign is_leaf  = rd_eff[EW-1] || (rd_eff == '0);
   assign leaf_sym = SW'(EW'(0) - rd_eff);

   // decode step control
   assign dec_stop   = finished_ff || (done_ff >= total_ff);
   assign dec_stall  = !dec_stop && is_leaf && pend_valid_ff && !slot_free;
   assign done_inc   = done_ff + CW'(1);
   assign done_reach = (done_inc >= total_ff);

   // add-code step: allocate a node when the child entry is empty
   assign alloc    = !first_ff && (rd_eff == '0);
   assign node_inc = (next_node_ff < NW'(hufd_pkg::MAX_NODE)) ? next_node_ff + NW'(1)
                                                              : next_node_ff;
   assign add_val  = alloc ? EW'(node_inc) : rd_eff;
   assign add_bit  = (cnt_ff < hufd_pkg::LEN_W'(hufd_pkg::CODE_W))
                     ? bits_ff[cnt_ff[hufd_pkg::CODE_IX_W-1:0]] : 1'b0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hufd_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == AW'(hufd_pkg::TREE_ENTRIES - 1)) begin
               state_in = hufd_pkg::ST_IDLE;
            end
         end
         hufd_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_cmd)
                  hufd_pkg::CMD_CLEAR: state_in = hufd_pkg::ST_CLEAR;
                  hufd_pkg::CMD_ADD: begin
                     if (req_if.code_len != '0) begin
                        state_in = hufd_pkg::ST_ADD;
                     end
                  end
                  hufd_pkg::CMD_DECODE: state_in = hufd_pkg::ST_DEC;
                  default: state_in = hufd_pkg::ST_IDLE;
               endcase
            end
         end
         hufd_pkg::ST_ADD: begin
            if (cnt_ff == '0) begin
               state_in = hufd_pkg::ST_LEAF;
            end
         end
         hufd_pkg::ST_LEAF: state_in = hufd_pkg::ST_IDLE;
         hufd_pkg::ST_DEC: begin
            if (dec_stop) begin
               state_in = hufd_pkg::ST_FLUSH;
            end else if (!dec_stall && (bpos_ff == '0)) begin
               state_in = hufd_pkg::ST_FLUSH;
            end
         end
         hufd_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || slot_free) begin
               state_in = hufd_pkg::ST_IDLE;
            end
         end
         default: state_in = hufd_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      next_node_in  = next_node_ff;
      walk_in       = walk_ff;
      done_in       = done_ff;
      finished_in   = finished_ff;
      total_in      = csr_if.valid ? csr_if.symbols_total : total_ff;
      addr_in       = addr_ff;
      sym_in        = sym_ff;
      bits_in       = bits_ff;
      cnt_in        = cnt_ff;
      first_in      = first_ff;
      byte_in       = byte_ff;
      bpos_in       = bpos_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_done_in  = pend_done_ff;
      rsp_valid_in  = rsp_if.ready ? 1'b0 : rsp_valid_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = '0;

      case (state_ff)
         // sweep the tree, root entry holds one
         hufd_pkg::ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = (clr_cnt_ff == AW'(1)) ? EW'(1) : '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
         end
         // command dispatch
         hufd_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_cmd)
                  hufd_pkg::CMD_CLEAR: begin
                     clr_cnt_in   = '0;
                     next_node_in = NW'(1);
                  end
                  hufd_pkg::CMD_ADD: begin
                     sym_in   = req_if.symbol;
                     bits_in  = req_if.code_bits;
                     cnt_in   = req_if.code_len - hufd_pkg::LEN_W'(1);
                     first_in = 1'b1;
                     addr_in  = AW'(1);
                  end
                  hufd_pkg::CMD_START: begin
                     walk_in     = NW'(1);
                     done_in     = '0;
                     finished_in = 1'b0;
                  end
                  hufd_pkg::CMD_DECODE: begin
                     byte_in = req_if.data_byte;
                     bpos_in = hufd_pkg::BPOS_W'(hufd_pkg::BYTE_W - 1);
                     addr_in = {walk_ff, req_if.data_byte[hufd_pkg::BYTE_W-1]};
                  end
                  default: addr_in = addr_ff;
               endcase
            end
         end
         // walk one code bit, allocating the entry when empty
         hufd_pkg::ST_ADD: begin
            if (alloc) begin
               ram_we       = 1'b1;
               ram_waddr    = addr_ff;
               ram_wdata    = EW'(node_inc);
               next_node_in = node_inc;
            end
            first_in = 1'b0;
            if (cnt_ff != '0) begin
               addr_in = {add_val[NW-1:0], add_bit};
               cnt_in  = cnt_ff - hufd_pkg::LEN_W'(1);
            end else begin
               addr_in = {add_val[NW-1:0], bits_ff[0]};
            end
         end
         // leaf holds minus the symbol
         hufd_pkg::ST_LEAF: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = EW'(0) - EW'(sym_ff);
         end
         // one data bit per cycle unless the output stalls, newest symbol held back for the last flag
         hufd_pkg::ST_DEC: begin
            if (!dec_stop && !dec_stall) begin
               if (is_leaf) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_sym_in   = pend_sym_ff;
                     rsp_last_in  = 1'b0;
                     rsp_done_in  = pend_done_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = leaf_sym;
                  pend_done_in  = done_reach;
                  done_in       = done_inc;
                  walk_in       = NW'(1);
                  if (done_reach) begin
                     finished_in = 1'b1;
                  end
               end else begin
                  walk_in = rd_eff[NW-1:0];
               end
               if (bpos_ff != '0) begin
                  bpos_in = bpos_ff - hufd_pkg::BPOS_W'(1);
                  addr_in = {(is_leaf ? NW'(1) : rd_eff[NW-1:0]),
                             byte_ff[bpos_ff - hufd_pkg::BPOS_W'(1)]};
               end
            end
         end
         // hand out the held symbol as last of the byte
         hufd_pkg::ST_FLUSH: begin
            if (pend_valid_ff && slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = pend_sym_ff;
               rsp_last_in   = 1'b1;
               rsp_done_in   = pend_done_ff;
               pend_valid_in = 1'b0;
            end
         end
         default: addr_in = addr_ff;
      endcase
   end

   // forwarding of a write to the entry being read
   assign fwd_hit_in  = ram_we && (ram_waddr == addr_in);
   assign fwd_data_in = ram_wdata;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hufd_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         next_node_ff  <= NW'(1);
         walk_ff       <= NW'(1);
         done_ff       <= '0;
         finished_ff   <= 1'b0;
         total_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         first_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         next_node_ff  <= next_node_in;
         walk_ff       <= walk_in;
         done_ff       <= done_in;
         finished_ff   <= finished_in;
         total_ff      <= total_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_hit_ff    <= fwd_hit_in;
         first_ff      <= first_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      sym_ff       <= sym_in;
      bits_ff      <= bits_in;
      cnt_ff       <= cnt_in;
      byte_ff      <= byte_in;
      bpos_ff      <= bpos_in;
      pend_sym_ff  <= pend_sym_in;
      pend_done_ff <= pend_done_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      fwd_data_ff  <= fwd_data_in;
   end

endmodule

FILE: test/hufd_decode_monitor.sv
`timescale 1ns / 1ps

module hufd_decode_monitor (
   input  logic clock,
   input  logic reset,
   hufd_req_if  req_if,
   hufd_rsp_if  rsp_if,
   hufd_csr_if  csr_if,
   output int   fail_count,
   output int   pending_count
);

   // one decoded symbol as it leaves the block
   typedef struct packed {
      logic [hufd_pkg::SYM_W-1:0] symbol;
      logic                       last_of_byte;
      logic                       stream_done;
   } decoded_symbol_type;

   // mirror of the decode tree and the stream state
   logic signed [hufd_pkg::ENTRY_W-1:0] tree_mirror [hufd_pkg::TREE_ENTRIES];
   logic [hufd_pkg::ADDR_W-1:0]         alloc_node;
   logic [hufd_pkg::ADDR_W-1:0]         walk_node;
   logic [hufd_pkg::COUNT_W-1:0]        symbols_seen;
   logic [hufd_pkg::COUNT_W-1:0]        stream_length;
   logic                                stream_over;

   decoded_symbol_type expected_symbols [$];

   // child entry of a node, wrapped to the tree size
   function automatic logic [hufd_pkg::ADDR_W-1:0] child_entry(
      logic [hufd_pkg::ADDR_W-1:0] node, logic b);
      return {node[hufd_pkg::ADDR_W-2:0], b};
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic wipe_tree();
      for (int i = 0; i < hufd_pkg::TREE_ENTRIES; i++)
         tree_mirror[i] = '0;
      tree_mirror[1] = hufd_pkg::ENTRY_W'(1);
      alloc_node = hufd_pkg::ADDR_W'(1);
   endtask

   // walk the code word from its top bit, allocating nodes, then place the leaf
   task automatic insert_code(logic [hufd_pkg::SYM_W-1:0] sym,
                              logic [hufd_pkg::CODE_W-1:0] code,
                              logic [hufd_pkg::LEN_W-1:0] len);
      logic [hufd_pkg::ADDR_W-1:0] idx;
      logic                        b;
      int                          p;
      if (len == '0)
         return;
      idx = hufd_pkg::ADDR_W'(1);
      for (p = int'(len) - 1; p > 0; p--) begin
         // bits above the code word read as zero
         b = (p < hufd_pkg::CODE_W) ? code[p] : 1'b0;
         idx = child_entry(tree_mirror[idx], b);
         if (tree_mirror[idx] == '0) begin
            if (alloc_node < hufd_pkg::MAX_NODE)
               alloc_node++;
            tree_mirror[idx] = alloc_node;
         end
      end
      idx = child_entry(tree_mirror[idx], code[0]);
      tree_mirror[idx] = -$signed({1'b0, sym});
   endtask

   // walk one byte msb first and queue the symbols it yields
   task automatic decode_byte(logic [hufd_pkg::BYTE_W-1:0] data);
      logic [hufd_pkg::ADDR_W-1:0]         idx;
      logic signed [hufd_pkg::ENTRY_W-1:0] entry;
      logic signed [hufd_pkg::ENTRY_W-1:0] magnitude;
      logic [hufd_pkg::SYM_W-1:0]          sym_buf [hufd_pkg::BYTE_W];
      logic                                done_buf [hufd_pkg::BYTE_W];
      decoded_symbol_type                  item;
      int                                  count;
      count = 0;
      for (int p = hufd_pkg::BYTE_W - 1; p >= 0; p--) begin
         if (stream_over || symbols_seen >= stream_length)
            break;
         idx = child_entry(walk_node, data[p]);
         entry = tree_mirror[idx];
         if (entry <= 0) begin
            magnitude = -entry;
            sym_buf[count] = magnitude[hufd_pkg::SYM_W-1:0];
            done_buf[count] = 1'b0;
            symbols_seen++;
            walk_node = hufd_pkg::ADDR_W'(1);
            if (symbols_seen >= stream_length) begin
               stream_over = 1'b1;
               done_buf[count] = 1'b1;
            end
            count++;
         end else begin
            walk_node = entry;
         end
      end
      for (int k = 0; k < count; k++) begin
         item.symbol = sym_buf[k];
         item.last_of_byte = (k == count - 1);
         item.stream_done = done_buf[k];
         expected_symbols.push_back(item);
      end
   endtask

   // compare results first, then apply writes and requests of this edge
   always @(posedge clock) begin
      decoded_symbol_type want;
      if (reset) begin
         fail_count = 0;
         wipe_tree();
         walk_node = hufd_pkg::ADDR_W'(1);
         symbols_seen = '0;
         stream_over = 1'b0;
         stream_length = '0;
         expected_symbols.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_symbols.size() == 0) begin
               report_mismatch("symbol with none expected", 32'(rsp_if.out_symbol), 32'd0);
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_if.out_symbol !== want.symbol)
                  report_mismatch("out_symbol", 32'(rsp_if.out_symbol), 32'(want.symbol));
               if (rsp_if.last_of_byte !== want.last_of_byte)
                  report_mismatch("last_of_byte", 32'(rsp_if.last_of_byte),
                                  32'(want.last_of_byte));
               if (rsp_if.stream_done !== want.stream_done)
                  report_mismatch("stream_done", 32'(rsp_if.stream_done),
                                  32'(want.stream_done));
            end
         end
         if (csr_if.valid && csr_if.ready)
            stream_length = csr_if.symbols_total;
         if (req_if.valid && req_if.ready) begin
            case (hufd_pkg::cmd_type'(req_if.cmd))
               hufd_pkg::CMD_CLEAR: begin
                  wipe_tree();
               end
               hufd_pkg::CMD_ADD: begin
                  insert_code(req_if.symbol, req_if.code_bits, req_if.code_len);
               end
               hufd_pkg::CMD_START: begin
                  walk_node = hufd_pkg::ADDR_W'(1);
                  symbols_seen = '0;
                  stream_over = 1'b0;
               end
               default: begin
                  decode_byte(req_if.data_byte);
               end
            endcase
         end
      end
      pending_count = expected_symbols.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT  = 5000;
   localparam int QUIET_WAIT  = 600;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_CODES   = 32;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   int   burst_left;
   int   hold_request;

   // current prefix code set
   logic [hufd_pkg::CODE_W-1:0] code_word [MAX_CODES];
   int                          code_size [MAX_CODES];
   int                          code_count;

   hufd_req_if req_ch ();
   hufd_rsp_if rsp_ch ();
   hufd_csr_if csr_ch ();

   huffman_tree_decoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   hufd_decode_monitor decode_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_ch),
      .rsp_if        (rsp_ch),
      .csr_if        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog on cycles without any transaction
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // result side stalls, plus a long hold-off on request
   initial begin
      int holds_taken;
      int hold_left;
      int stall_mode;
      int mode_left;
      int tick;
      holds_taken = 0;
      hold_left = 0;
      stall_mode = 0;
      mode_left = 0;
      tick = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != holds_taken) begin
            holds_taken = hold_request;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
         end else begin
            mode_left--;
         end
         tick++;
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ch.ready = 1'b1;
               1: rsp_ch.ready = 1'($urandom_range(0, 1));
               2: rsp_ch.ready = (tick % 3 == 0);
               default: rsp_ch.ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // one request transaction, then the sender may pause between bursts
   task automatic send_request(hufd_pkg::cmd_type cmd, logic [hufd_pkg::SYM_W-1:0] sym,
                               logic [hufd_pkg::CODE_W-1:0] code,
                               logic [hufd_pkg::LEN_W-1:0] len,
                               logic [hufd_pkg::BYTE_W-1:0] data);
      int gap;
      req_ch.cmd = cmd;
      req_ch.symbol = sym;
      req_ch.code_bits = code;
      req_ch.code_len = len;
      req_ch.data_byte = data;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic add_code(logic [hufd_pkg::SYM_W-1:0] sym, logic [hufd_pkg::CODE_W-1:0] code,
                           logic [hufd_pkg::LEN_W-1:0] len);
      send_request(hufd_pkg::CMD_ADD, sym, code, len, hufd_pkg::BYTE_W'($urandom));
   endtask

   task automatic decode(logic [hufd_pkg::BYTE_W-1:0] data);
      send_request(hufd_pkg::CMD_DECODE, hufd_pkg::SYM_W'($urandom),
                   hufd_pkg::CODE_W'($urandom), hufd_pkg::LEN_W'($urandom), data);
   endtask

   task automatic clear_tree();
      send_request(hufd_pkg::CMD_CLEAR, hufd_pkg::SYM_W'($urandom),
                   hufd_pkg::CODE_W'($urandom), hufd_pkg::LEN_W'($urandom),
                   hufd_pkg::BYTE_W'($urandom));
   endtask

   task automatic start_stream();
      send_request(hufd_pkg::CMD_START, hufd_pkg::SYM_W'($urandom),
                   hufd_pkg::CODE_W'($urandom), hufd_pkg::LEN_W'($urandom),
                   hufd_pkg::BYTE_W'($urandom));
   endtask

   // register write once the block has drained and gone quiet
   task automatic write_symbols_total(logic [hufd_pkg::COUNT_W-1:0] total);
      req_ch.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (QUIET_WAIT) @(negedge clock);
      csr_ch.symbols_total = total;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // complete prefix code by splitting random leaves
   task automatic build_code_set(int count);
      int k;
      code_word[0] = '0;
      code_size[0] = 1;
      code_word[1] = hufd_pkg::CODE_W'(1);
      code_size[1] = 1;
      code_count = 2;
      while (code_count < count) begin
         k = $urandom_range(0, code_count - 1);
         if (code_size[k] < hufd_pkg::CODE_W) begin
            code_word[code_count] = (code_word[k] << 1) | 1'b1;
            code_size[code_count] = code_size[k] + 1;
            code_word[k] = code_word[k] << 1;
            code_size[k]++;
            code_count++;
         end
      end
   endtask

   // clear, load a fresh code set, start, then decode with some noise mixed in
   task automatic run_stream(int num_codes, int num_bytes, bit with_hold);
      int first;
      clear_tree();
      build_code_set(num_codes);
      first = $urandom_range(0, code_count - 1);
      for (int i = 0; i < code_count; i++)
         add_code(hufd_pkg::SYM_W'($urandom), code_word[(first + i) % code_count],
                  hufd_pkg::LEN_W'(code_size[(first + i) % code_count]));
      start_stream();
      if (with_hold)
         hold_request++;
      for (int i = 0; i < num_bytes; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_request(hufd_pkg::cmd_type'($urandom_range(0, 3)),
                         hufd_pkg::SYM_W'($urandom), hufd_pkg::CODE_W'($urandom),
                         hufd_pkg::LEN_W'($urandom_range(0, 31)),
                         hufd_pkg::BYTE_W'($urandom));
         else
            decode(hufd_pkg::BYTE_W'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      hold_request = 0;
      burst_left = 4;
      req_ch.valid = 1'b0;
      req_ch.cmd = hufd_pkg::CMD_CLEAR;
      req_ch.symbol = '0;
      req_ch.code_bits = '0;
      req_ch.code_len = '0;
      req_ch.data_byte = '0;
      csr_ch.valid = 1'b0;
      csr_ch.symbols_total = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty tree, edge codes, walks through leaves, restart and clear
      write_symbols_total(24'hFFFFFF);
      decode(8'hFF);
      decode(8'h00);
      add_code(8'hFF, 16'h0000, 5'd1);
      add_code(8'h80, 16'hFFFF, 5'd16);
      add_code(8'h11, 16'h0000, 5'd0);
      add_code(8'h07, 16'h1234, 5'd20);
      add_code(8'h42, 16'h0001, 5'd2);
      decode(8'h00);
      decode(8'hFF);
      decode(8'hA5);
      decode(8'h7F);
      start_stream();
      decode(8'hFF);
      clear_tree();
      decode(8'h5A);
      add_code(8'h00, 16'h0002, 5'd2);
      add_code(8'h01, 16'h0004, 5'd3);
      add_code(8'hC3, 16'hFFF0, 5'd31);
      decode(8'h80);
      decode(8'hC3);

      // node space exhaustion with long random codes
      clear_tree();
      for (int i = 0; i < 20; i++)
         add_code(hufd_pkg::SYM_W'($urandom), hufd_pkg::CODE_W'($urandom), 5'd16);
      start_stream();
      for (int i = 0; i < 4; i++)
         decode(hufd_pkg::BYTE_W'($urandom));

      // streams under several symbol totals, one with the receiver held off
      write_symbols_total(24'd0);
      run_stream($urandom_range(2, 6), 4, 1'b0);
      write_symbols_total(24'd1);
      run_stream($urandom_range(2, 6), 4, 1'b0);
      write_symbols_total(24'hFFFFFF);
      run_stream($urandom_range(6, 12), 10, 1'b1);
      write_symbols_total(24'd7);
      run_stream($urandom_range(2, 6), 6, 1'b0);
      write_symbols_total(hufd_pkg::COUNT_W'($urandom_range(2, 40)));
      run_stream($urandom_range(2, 8), 6, 1'b0);
      write_symbols_total(24'hFFFFFE);
      run_stream($urandom_range(2, 6), 5, 1'b0);

      // drain and settle
      req_ch.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
